/* rtl/core/n_queens_solution_enumerator_defines.svh */
// Assertion macros for the n-queens solution enumerator.
`ifndef N_QUEENS_SOLUTION_ENUMERATOR_DEFINES_SVH
`define N_QUEENS_SOLUTION_ENUMERATOR_DEFINES_SVH
`ifndef SYNTH
`define NQSE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("nqse: invariant violated");
`define NQSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nqse: implication violated");
`define NQSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nqse: next-cycle check violated");
`else
`define NQSE_ASSERT(lbl, clk, rst_n, prop)
`define NQSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define NQSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/nqse_pkg.sv */
// Shared constants, types and codes of the n-queens solution enumerator.
package nqse_pkg;

	localparam int NQ_MAX_SIZE  = 8;
	localparam int NQ_BOARD_MAX = 8;
	localparam int COL_W        = 4;
	localparam int ROW_W        = 3;
	localparam int SIZE_W       = 4;
	localparam int BOARD_W      = 64;
	localparam int BIDX_W       = $clog2(BOARD_W);
	localparam int ADDR_W       = 3;
	localparam int DATA_W       = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET     = SIZE_W'(8);
	localparam logic              REG_BOARD_SIZE = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT
	} nq_state_t;

	typedef struct packed {
		logic [NQ_BOARD_MAX-1:0] rows;
		logic [NQ_BOARD_MAX-1:0] up;
		logic [NQ_BOARD_MAX-1:0] dn;
	} occ_t;

	typedef struct packed {
		logic [COL_W-1:0] depth;
		logic             wr_en;
		logic [COL_W-1:0] wr_col;
		logic [ROW_W-1:0] wr_row;
	} cell_cmd_t;

	typedef struct packed {
		logic             placed;
		logic             wr_en;
		logic [ROW_W-1:0] wr_row;
	} cell_ctl_t;

endpackage

/* rtl/core/nqse_req_if.sv */
// Request channel: valid, ready and the restart flag.
interface nqse_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

/* rtl/core/nqse_rsp_if.sv */
// Response channel: valid, ready, found flag and the board.
interface nqse_rsp_if import nqse_pkg::*;;
	logic               valid;
	logic               ready;
	logic               found;
	logic [BOARD_W-1:0] board_cells;

	modport source (output valid, output found, output board_cells, input ready);
	modport sink (input valid, input found, input board_cells, output ready);
endinterface

/* rtl/core/nqse_cell.sv */
// One column cell: holds its queen row and passes attack masks to the next column.
module nqse_cell import nqse_pkg::*; (
	input  logic                    clk,
	input  cell_ctl_t               ctl,
	input  occ_t                    occ_in,
	output occ_t                    occ_out,
	output logic [NQ_BOARD_MAX-1:0] free_rows,
	output logic [ROW_W-1:0]        row
);

	logic [ROW_W-1:0]        row_q;
	logic [NQ_BOARD_MAX-1:0] qbit;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			row_q <= ctl.wr_row;
		end
	end

	always_comb begin
		qbit         = ctl.placed ? (NQ_BOARD_MAX'(1) << row_q) : '0;
		occ_out.rows = occ_in.rows | qbit;
		occ_out.dn   = (occ_in.dn | qbit) << 1;
		occ_out.up   = (occ_in.up | qbit) >> 1;
		free_rows    = ~(occ_in.rows | occ_in.up | occ_in.dn);
	end

	assign row = row_q;

endmodule

/* rtl/core/nqse_ctrl.sv */
// Search sequencer, size register and response register.
`include "n_queens_solution_enumerator_defines.svh"
module nqse_ctrl import nqse_pkg::*; #(
	parameter int MAX_SIZE = NQ_MAX_SIZE
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	input  logic [NQ_BOARD_MAX-1:0] free_rows [MAX_SIZE],
	input  logic [ROW_W-1:0]        cell_rows [MAX_SIZE],
	output cell_cmd_t               cmd,
	nqse_req_if.sink                req,
	nqse_rsp_if.source              rsp
);

	nq_state_t               st_q, st_d;
	logic [SIZE_W-1:0]       size_q;
	logic [COL_W-1:0]        col_q, col_d;
	logic [COL_W-1:0]        start_q, start_d;
	logic                    exh_q, exh_d;
	logic                    emit_found_q, emit_found_d;
	logic                    out_valid_q;
	logic                    found_q;
	logic [BOARD_W-1:0]      board_q;

	logic                    cfg_wr;
	logic [COL_W-1:0]        n_eff;
	logic [COL_W-1:0]        last_col;
	logic [COL_W-1:0]        prev_col;
	logic [NQ_BOARD_MAX-1:0] sel_free;
	logic [ROW_W-1:0]        row_last;
	logic [ROW_W-1:0]        row_prev;
	logic [NQ_BOARD_MAX-1:0] cand;
	logic                    found_any;
	logic [ROW_W-1:0]        pick;
	logic                    load_out;
	logic [BOARD_W-1:0]      board_d;
	logic                    eff_exh;
	logic [COL_W-1:0]        base_col;

	assign cfg_wr = psel & penable & pwrite & (paddr[ADDR_W-1] == REG_BOARD_SIZE);
	assign prdata = (paddr[ADDR_W-1] == REG_BOARD_SIZE) ? DATA_W'(size_q) : '0;

	always_comb begin
		if (size_q == '0) begin
			n_eff = COL_W'(1);
		end else if (COL_W'(size_q) > COL_W'(MAX_SIZE)) begin
			n_eff = COL_W'(MAX_SIZE);
		end else begin
			n_eff = COL_W'(size_q);
		end
		last_col = n_eff - COL_W'(1);
		prev_col = col_q - COL_W'(1);
	end

	// pick the cells seen by the current, previous and last columns
	always_comb begin
		sel_free = '0;
		row_last = '0;
		row_prev = '0;
		for (int k = 0; k < MAX_SIZE; k++) begin
			if (COL_W'(k) == col_q) begin
				sel_free = sel_free | free_rows[k];
			end
			if (COL_W'(k) == last_col) begin
				row_last = row_last | cell_rows[k];
			end
			if (COL_W'(k) == prev_col) begin
				row_prev = row_prev | cell_rows[k];
			end
		end
	end

	always_comb begin
		cand = '0;
		pick = '0;
		for (int r = 0; r < NQ_BOARD_MAX; r++) begin
			cand[r] = sel_free[r] && (COL_W'(r) >= start_q) && (COL_W'(r) < n_eff);
		end
		for (int r = NQ_BOARD_MAX - 1; r >= 0; r--) begin
			if (cand[r]) begin
				pick = ROW_W'(r);
			end
		end
		found_any = |cand;
	end

	always_comb begin
		logic [BIDX_W:0] idx;
		board_d = '0;
		for (int k = 0; k < MAX_SIZE; k++) begin
			idx = (BIDX_W+1)'(cell_rows[k]) * (BIDX_W+1)'(n_eff) + (BIDX_W+1)'(k);
			if (COL_W'(k) < n_eff) begin
				board_d[idx[BIDX_W-1:0]] = 1'b1;
			end
		end
	end

	assign eff_exh  = req.restart ? 1'b0 : exh_q;
	assign base_col = req.restart ? '0 : col_q;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (req.valid) begin
					st_d = eff_exh ? ST_EMIT : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (found_any && (col_q + COL_W'(1) == n_eff)) begin
					st_d = ST_EMIT;
				end else if (!found_any && (col_q == '0)) begin
					st_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || rsp.ready) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// outputs and datapath
	always_comb begin
		col_d        = col_q;
		start_d      = start_q;
		exh_d        = exh_q;
		emit_found_d = emit_found_q;
		load_out     = 1'b0;
		req.ready    = 1'b0;
		cmd.depth    = col_q;
		cmd.wr_en    = 1'b0;
		cmd.wr_col   = col_q;
		cmd.wr_row   = pick;
		case (st_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					exh_d = eff_exh;
					if (eff_exh) begin
						emit_found_d = 1'b0;
					end else if (base_col == n_eff) begin
						col_d   = last_col;
						start_d = COL_W'(row_last) + COL_W'(1);
					end else begin
						col_d   = base_col;
						start_d = '0;
					end
				end
			end
			ST_SEARCH: begin
				if (found_any) begin
					cmd.wr_en    = 1'b1;
					col_d        = col_q + COL_W'(1);
					start_d      = '0;
					emit_found_d = 1'b1;
				end else if (col_q == '0) begin
					exh_d        = 1'b1;
					emit_found_d = 1'b0;
				end else begin
					col_d   = prev_col;
					start_d = COL_W'(row_prev) + COL_W'(1);
				end
			end
			ST_EMIT: begin
				load_out = !out_valid_q || rsp.ready;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			size_q       <= SIZE_RESET;
			col_q        <= '0;
			start_q      <= '0;
			exh_q        <= 1'b0;
			emit_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			st_q         <= st_d;
			start_q      <= start_d;
			emit_found_q <= emit_found_d;
			if (cfg_wr) begin
				size_q <= pwdata[SIZE_W-1:0];
				col_q  <= '0;
				exh_q  <= 1'b0;
			end else begin
				col_q <= col_d;
				exh_q <= exh_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q <= emit_found_q;
			board_q <= emit_found_q ? board_d : '0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = found_q;
	assign rsp.board_cells = board_q;

	`NQSE_ASSERT(a_col_in_range, clk, arst_n, col_q <= n_eff)
	`NQSE_ASSERT_IMPL(a_exh_at_root, clk, arst_n, exh_q, col_q == '0)
	`NQSE_ASSERT_IMPL(a_search_live, clk, arst_n, st_q == ST_SEARCH, !exh_q)
	`NQSE_ASSERT_NEXT(a_full_board_emits, clk, arst_n, (st_q == ST_SEARCH) && found_any && (col_q + COL_W'(1) == n_eff) && !cfg_wr, (st_q == ST_EMIT) && emit_found_q)
	`NQSE_ASSERT_IMPL(a_found_has_queens, clk, arst_n, out_valid_q && found_q, board_q != '0)

endmodule

/* rtl/core/n_queens_solution_enumerator.sv */
// Each request runs a backtracking search to the next solution through the cell
// chain (one column placed or withdrawn per cycle); an exhausted search answers
// without searching. One request at a time is served; the response register frees
// the request side once it is loaded.
// Reset (arst_n low, asynchronous): board_size 8, search at its first solution.
module n_queens_solution_enumerator import nqse_pkg::*; #(
	parameter int MAX_SIZE = NQ_MAX_SIZE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	nqse_req_if.sink          req,
	nqse_rsp_if.source        rsp
);

	occ_t                    occ [MAX_SIZE+1];
	cell_ctl_t               ctl [MAX_SIZE];
	logic [NQ_BOARD_MAX-1:0] free_rows [MAX_SIZE];
	logic [ROW_W-1:0]        cell_rows [MAX_SIZE];
	cell_cmd_t               cmd;

	assign pready = 1'b1;
	assign occ[0] = '0;

	for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
		assign ctl[k].placed = COL_W'(k) < cmd.depth;
		assign ctl[k].wr_en  = cmd.wr_en && (cmd.wr_col == COL_W'(k));
		assign ctl[k].wr_row = cmd.wr_row;

		nqse_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[k]),
			.occ_in    (occ[k]),
			.occ_out   (occ[k+1]),
			.free_rows (free_rows[k]),
			.row       (cell_rows[k])
		);
	end

	nqse_ctrl #(
		.MAX_SIZE (MAX_SIZE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.free_rows (free_rows),
		.cell_rows (cell_rows),
		.cmd       (cmd),
		.req       (req),
		.rsp       (rsp)
	);

endmodule

/* test/tb_n_queens_solution_enumerator.sv */
// Testbench for the n-queens solution enumerator: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

module tb_n_queens_solution_enumerator;
	import nqse_pkg::*;

	typedef struct {
		bit                 found;
		logic [BOARD_W-1:0] cells;
	} board_answer_t;

	class queens_scoreboard;
		logic [SIZE_W-1:0] size_reg;
		logic [ROW_W-1:0]  placed_row [NQ_MAX_SIZE];
		int unsigned       cur_col;
		logic [7:0]        rows_used;
		logic [14:0]       up_used;
		logic [14:0]       dn_used;
		bit                exhausted;
		board_answer_t     answer_q [$];
		int                errors;

		function new();
			errors = 0;
			size_reg = SIZE_RESET;
			clear_search();
		endfunction

		function void clear_search();
			foreach (placed_row[k])
				placed_row[k] = '0;
			cur_col = 0;
			rows_used = '0;
			up_used = '0;
			dn_used = '0;
			exhausted = 1'b0;
		endfunction

		function int unsigned eff_size();
			if (size_reg == 0)
				return 1;
			if (size_reg > NQ_MAX_SIZE)
				return NQ_MAX_SIZE;
			return size_reg;
		endfunction

		function void flip(int unsigned n, int unsigned c, int unsigned r);
			rows_used[r] = ~rows_used[r];
			up_used[n - 1 + c - r] = ~up_used[n - 1 + c - r];
			dn_used[r + c] = ~dn_used[r + c];
		endfunction

		function void set_board_size(logic [SIZE_W-1:0] v);
			size_reg = v;
			clear_search();
		endfunction

		// advance the search to the next solution and queue the answer
		function void note_request(bit restart);
			int unsigned   n, c, r, start, k;
			bit            done;
			board_answer_t res;
			n = eff_size();
			if (restart)
				clear_search();
			res.found = 1'b0;
			res.cells = '0;
			if (!exhausted) begin
				c = cur_col;
				start = 0;
				if (c >= n) begin
					c = n - 1;
					r = placed_row[c];
					flip(n, c, r);
					start = r + 1;
				end
				done = 1'b0;
				while (!done) begin
					if (c == n) begin
						cur_col = n;
						for (k = 0; k < n; k++)
							res.cells[placed_row[k] * n + k] = 1'b1;
						res.found = 1'b1;
						done = 1'b1;
					end else begin
						for (r = start; r < n; r++)
							if (!rows_used[r] && !up_used[n - 1 + c - r] && !dn_used[r + c])
								break;
						if (r < n) begin
							flip(n, c, r);
							placed_row[c] = r[ROW_W-1:0];
							c++;
							start = 0;
						end else if (c == 0) begin
							clear_search();
							exhausted = 1'b1;
							done = 1'b1;
						end else begin
							c--;
							r = placed_row[c];
							flip(n, c, r);
							start = r + 1;
						end
					end
				end
			end
			answer_q = {answer_q, res};
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic found, logic [BOARD_W-1:0] cells);
			board_answer_t exp;
			if (answer_q.size() == 0) begin
				report($sformatf("unexpected result found=%b cells=%h", found, cells));
			end else begin
				exp = answer_q.pop_front();
				if (found !== exp.found)
					report($sformatf("found %b, want %b", found, exp.found));
				if (cells !== exp.cells)
					report($sformatf("board_cells %h, want %h", cells, exp.cells));
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	nqse_req_if req_ch ();
	nqse_rsp_if rsp_ch ();

	queens_scoreboard sb;
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int hold_cycles  = 0;

	n_queens_solution_enumerator u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("Verification failed");
		$finish;
	end

	// hold off or stall the response side
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_cycles--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			sb.note_request(req_ch.restart);
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result(rsp_ch.found, rsp_ch.board_cells);
	end

	task automatic write_board_size(logic [SIZE_W-1:0] v);
		logic [DATA_W-1:0] data;
		data = {$urandom} ;
		data[SIZE_W-1:0] = v;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4 * int'(REG_BOARD_SIZE));
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_board_size(v);
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[SIZE_W-1:0] !== v)
			sb.report($sformatf("board_size read %h, want %h", prdata[SIZE_W-1:0], v));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic push_request(bit rst);
		if ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		req_ch.valid   <= 1'b1;
		req_ch.restart <= rst;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// drop valid and wait for every outstanding answer
	task automatic finish_batch();
		req_ch.valid <= 1'b0;
		while (sb.answer_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_segment(int items);
		int                pct;
		int                pick;
		logic [SIZE_W-1:0] sz;
		pick = $urandom_range(99);
		if (pick < 8)
			sz = '0;
		else if (pick < 16)
			sz = SIZE_W'($urandom_range(9, 15));
		else
			sz = SIZE_W'($urandom_range(1, NQ_MAX_SIZE));
		write_board_size(sz);
		pct = $urandom_range(0, 6);
		repeat (items)
			push_request($urandom_range(99) < pct);
		finish_batch();
	endtask

	initial begin
		int tx_pct [3];
		int rx_pct [3];
		int left;
		int cnt;
		tx_pct = '{34, 68, 0};
		rx_pct = '{68, 34, 0};
		sb = new();
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		req_ch.valid   = 1'b0;
		req_ch.restart = 1'b0;
		tx_idle_pct  = tx_pct[0];
		rx_stall_pct = rx_pct[0];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_request(1'b0);
		push_request(1'b1);
		push_request(1'b0);
		finish_batch();
		write_board_size(4'd0);
		push_request(1'b0);
		push_request(1'b0);
		push_request(1'b0);
		push_request(1'b1);
		finish_batch();
		write_board_size(4'd3);
		push_request(1'b0);
		push_request(1'b1);
		finish_batch();
		write_board_size(4'd2);
		push_request(1'b0);
		finish_batch();
		write_board_size(4'd15);
		push_request(1'b0);
		push_request(1'b1);
		finish_batch();
		write_board_size(4'd4);
		push_request(1'b0);
		push_request(1'b0);
		push_request(1'b1);
		push_request(1'b0);
		push_request(1'b0);
		push_request(1'b0);
		finish_batch();
		write_board_size(4'd1);
		push_request(1'b0);
		push_request(1'b0);
		finish_batch();

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct  = tx_pct[ph];
			rx_stall_pct = rx_pct[ph];
			left = 334;
			while (left > 0) begin
				cnt = $urandom_range(40, 140);
				if (cnt > left)
					cnt = left;
				if (ph == 2 && left == 334)
					hold_cycles = 1500;
				random_segment(cnt);
				left -= cnt;
			end
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* n_queens_solution_enumerator.f */
+incdir+rtl/core
rtl/core/nqse_pkg.sv
rtl/core/nqse_req_if.sv
rtl/core/nqse_rsp_if.sv
rtl/core/nqse_cell.sv
rtl/core/nqse_ctrl.sv
rtl/core/n_queens_solution_enumerator.sv
test/tb_n_queens_solution_enumerator.sv
